// ===== src/rpe_pkg.sv =====
// Shared constants and controller/datapath interface types for the Prewitt edge block.
package rpe_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = 10;
    localparam int ROW_W      = 12;
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int PIX_W      = 24;
    localparam int ABS_W      = 10;
    localparam int SQ_W       = 21;
    localparam int OP_W       = 17;
    localparam int STEP_W     = 3;

    localparam logic [FW_W-1:0] FW_RESET = 11'd640;
    localparam logic [FH_W-1:0] FH_RESET = 13'd480;
    localparam logic [FW_W-1:0] FW_MIN   = 11'd3;
    localparam logic [FW_W-1:0] FW_MAX   = 11'd1024;
    localparam logic [FH_W-1:0] FH_MIN   = 13'd3;
    localparam logic [FH_W-1:0] FH_MAX   = 13'd4096;

    localparam logic [STEP_W-1:0] ROOT_LAST = 3'd7;
    localparam logic [OP_W-1:0]   ROOT_ONE  = 17'h04000;
    localparam logic [7:0]        EDGE_SAT  = 8'd255;

    // Register indexes, taken from paddr[2].
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic accept;
        logic step;
        logic square;
        logic root;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic emit;
        logic out_free;
    } t_sts;

endpackage

// ===== src/rpe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rpe_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/rpe_ctrl.sv =====
// Sequencer that steps one pixel through read, gradient, squaring, square root and output load.
module rpe_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  rpe_pkg::t_sts i_sts,
    output rpe_pkg::t_cmd o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_READ   = 6'b000010,
        S_SQUARE = 6'b000100,
        S_ROOT   = 6'b001000,
        S_HOLD   = 6'b010000,
        S_SPARE  = 6'b100000
    } t_state;

    t_state                      r_state, n_state;
    logic [rpe_pkg::STEP_W-1:0]  r_step, n_step;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_READ;
                end
            end
            S_READ: begin
                o_cmd.step = 1'b1;
                n_state    = i_sts.emit ? S_SQUARE : S_IDLE;
            end
            S_SQUARE: begin
                o_cmd.square = 1'b1;
                n_step       = '0;
                n_state      = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.root = 1'b1;
                n_step     = r_step + 1'b1;
                if (r_step == rpe_pkg::ROOT_LAST) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

`ifndef SYNTHESIS
    a_root_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROOT && r_step == rpe_pkg::ROOT_LAST) |=> (r_state == S_HOLD))
        else $error("root iteration did not finish after the last step");
    a_no_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ && !i_sts.emit) |=> (r_state == S_IDLE))
        else $error("border pixel did not return to idle");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> i_sts.out_free)
        else $error("output register loaded while occupied");
`endif

endmodule

// ===== src/rpe_dp.sv =====
// Datapath: counters, line stores, window, gradients, square root and output register.
module rpe_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rpe_pkg::t_cmd               i_cmd,
    output rpe_pkg::t_sts               o_sts,
    input  logic                        i_restart,
    input  logic [rpe_pkg::FW_W-1:0]    i_frame_width,
    input  logic [rpe_pkg::FH_W-1:0]    i_frame_height,
    input  logic [7:0]                  i_pixel_blue,
    input  logic [7:0]                  i_pixel_green,
    input  logic [7:0]                  i_pixel_red,
    input  logic                        i_ready,
    output logic                        o_valid,
    output logic [7:0]                  o_edge_blue,
    output logic [7:0]                  o_edge_green,
    output logic [7:0]                  o_edge_red,
    output logic [rpe_pkg::COL_W-1:0]   o_center_col,
    output logic [rpe_pkg::ROW_W-1:0]   o_center_row,
    output logic                        o_frame_done
);

    localparam int CW = rpe_pkg::COL_W;
    localparam int RW = rpe_pkg::ROW_W;
    localparam int FW = rpe_pkg::FW_W;
    localparam int FH = rpe_pkg::FH_W;
    localparam int PW = rpe_pkg::PIX_W;
    localparam int AW = rpe_pkg::ABS_W;
    localparam int OW = rpe_pkg::OP_W;

    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [PW-1:0] r_px;
    logic [PW-1:0] r_win [6];
    logic [AW-1:0] r_ah [3];
    logic [AW-1:0] r_av [3];
    logic          r_sat [3];
    logic [OW-1:0] r_op [3];
    logic [OW-1:0] r_res [3];
    logic [OW-1:0] r_one;
    logic [CW-1:0] r_ccol;
    logic [RW-1:0] r_crow;
    logic          r_cdone;
    logic          r_ov;
    logic [7:0]    r_eb, r_eg, r_er;
    logic [CW-1:0] r_ocol;
    logic [RW-1:0] r_orow;
    logic          r_odone;

    logic [FW-1:0] w_use;
    logic [FH-1:0] h_use;
    logic [CW-1:0] col;
    logic [RW-1:0] row;
    logic [PW-1:0] up, lo;
    logic          last_col, last_row;

    always_comb begin
        if (i_frame_width < rpe_pkg::FW_MIN) begin
            w_use = rpe_pkg::FW_MIN;
        end else if (i_frame_width > rpe_pkg::FW_MAX) begin
            w_use = rpe_pkg::FW_MAX;
        end else begin
            w_use = i_frame_width;
        end
        if (i_frame_height < rpe_pkg::FH_MIN) begin
            h_use = rpe_pkg::FH_MIN;
        end else if (i_frame_height > rpe_pkg::FH_MAX) begin
            h_use = rpe_pkg::FH_MAX;
        end else begin
            h_use = i_frame_height;
        end
    end

    logic [FW-1:0] w_m1;
    logic [FH-1:0] h_m1;
    assign w_m1 = w_use - 1'b1;
    assign h_m1 = h_use - 1'b1;
    assign col  = ({1'b0, r_col} >= w_use) ? w_m1[CW-1:0] : r_col;
    assign row  = ({1'b0, r_row} >= h_use) ? h_m1[RW-1:0] : r_row;
    assign last_col = ({1'b0, col} == w_m1);
    assign last_row = ({1'b0, row} == h_m1);

    assign o_sts.emit     = (col >= CW'(2)) && (row >= RW'(2));
    assign o_sts.out_free = !r_ov || i_ready;

    rpe_ram #(.WIDTH(PW), .DEPTH(rpe_pkg::MAX_WIDTH)) u_upper (
        .i_clk  (i_clk),
        .i_we   (i_cmd.step),
        .i_waddr(col),
        .i_wdata(lo),
        .i_raddr(col),
        .o_rdata(up)
    );

    rpe_ram #(.WIDTH(PW), .DEPTH(rpe_pkg::MAX_WIDTH)) u_lower (
        .i_clk  (i_clk),
        .i_we   (i_cmd.step),
        .i_waddr(col),
        .i_wdata(r_px),
        .i_raddr(col),
        .o_rdata(lo)
    );

    // Per channel gradients; values are 8-bit so sums fit 10 bits and differences 11.
    localparam int SQ_W_L = rpe_pkg::SQ_W;
    logic [AW-1:0] ah [3];
    logic [AW-1:0] av [3];
    logic [SQ_W_L-1:0] sq [3];
    logic [OW-1:0] trial [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            logic [AW-1:0] top, bot, lft, rgt;
            logic [AW:0]   hd, vd;
            top = AW'(r_win[3][c*8 +: 8]) + AW'(r_win[0][c*8 +: 8]) + AW'(up[c*8 +: 8]);
            bot = AW'(r_win[5][c*8 +: 8]) + AW'(r_win[2][c*8 +: 8]) + AW'(r_px[c*8 +: 8]);
            lft = AW'(r_win[3][c*8 +: 8]) + AW'(r_win[4][c*8 +: 8]) + AW'(r_win[5][c*8 +: 8]);
            rgt = AW'(up[c*8 +: 8]) + AW'(lo[c*8 +: 8]) + AW'(r_px[c*8 +: 8]);
            hd  = {1'b0, lft} - {1'b0, rgt};
            vd  = {1'b0, top} - {1'b0, bot};
            ah[c] = hd[AW] ? AW'(-hd) : hd[AW-1:0];
            av[c] = vd[AW] ? AW'(-vd) : vd[AW-1:0];
            sq[c] = SQ_W_L'(r_ah[c]) * SQ_W_L'(r_ah[c]) + SQ_W_L'(r_av[c]) * SQ_W_L'(r_av[c]);
            trial[c] = r_res[c] + r_one;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= '0;
            end
        end else if (i_restart) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.step) begin
            r_win[3] <= r_win[0];
            r_win[4] <= r_win[1];
            r_win[5] <= r_win[2];
            r_win[0] <= up;
            r_win[1] <= lo;
            r_win[2] <= r_px;
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : row + 1'b1;
            end else begin
                r_col <= col + 1'b1;
                r_row <= row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_px <= {i_pixel_red, i_pixel_green, i_pixel_blue};
        end
        if (i_cmd.step) begin
            r_ccol  <= col - 1'b1;
            r_crow  <= row - 1'b1;
            r_cdone <= last_col && last_row;
            for (int c = 0; c < 3; c++) begin
                r_ah[c] <= ah[c];
                r_av[c] <= av[c];
            end
        end
        if (i_cmd.square) begin
            r_one <= rpe_pkg::ROOT_ONE;
            for (int c = 0; c < 3; c++) begin
                r_sat[c] <= sq[c] >= SQ_W_L'(65536);
                r_op[c]  <= OW'(sq[c][15:0]);
                r_res[c] <= '0;
            end
        end
        if (i_cmd.root) begin
            r_one <= r_one >> 2;
            for (int c = 0; c < 3; c++) begin
                if (r_op[c] >= trial[c]) begin
                    r_op[c]  <= r_op[c] - trial[c];
                    r_res[c] <= (r_res[c] >> 1) + r_one;
                end else begin
                    r_res[c] <= r_res[c] >> 1;
                end
            end
        end
        if (i_cmd.load) begin
            r_eb    <= r_sat[0] ? rpe_pkg::EDGE_SAT : r_res[0][7:0];
            r_eg    <= r_sat[1] ? rpe_pkg::EDGE_SAT : r_res[1][7:0];
            r_er    <= r_sat[2] ? rpe_pkg::EDGE_SAT : r_res[2][7:0];
            r_ocol  <= r_ccol;
            r_orow  <= r_crow;
            r_odone <= r_cdone;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.load) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    assign o_valid      = r_ov;
    assign o_edge_blue  = r_eb;
    assign o_edge_green = r_eg;
    assign o_edge_red   = r_er;
    assign o_center_col = r_ocol;
    assign o_center_row = r_orow;
    assign o_frame_done = r_odone;

`ifndef SYNTHESIS
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_col} < w_use))
        else $error("column count beyond the frame width");
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_row} < h_use))
        else $error("row count beyond the frame height");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_ready) |=> r_ov)
        else $error("pending result dropped");
`endif

endmodule

// ===== src/rgb_prewitt_edge_magnitude.sv =====
// Top level of the RGB Prewitt edge magnitude block with its register port.
//
// Pixels enter on the input channel (i_valid/o_ready) in raster order, one
// beat per pixel. Each pixel that completes the 3x3 window of an interior
// pixel yields one result beat on the output channel (o_valid/i_ready): the
// per-channel gradient magnitudes, saturated at 255, the window centre's
// column and row, and a flag on the last interior result of the frame.
// Border pixels update the line stores and window but produce no beat.
// A pixel is taken only while the sequencer is idle. A border pixel then
// returns to idle after the line store read; an interior pixel goes through
// line store read, gradient, squaring, eight iterations of the per-channel
// bit-by-bit square root units, and the output load, which waits in the hold
// state until the output register is free. The square root iterations set the
// throughput. If the receiver stalls, the result waits in the output register
// while the next pixel is accepted and processed; the block stops only when a
// second result is ready to load. Reset clears the counters, window and output
// valid, and sets the frame size to 640 by 480. Any register write restarts
// the frame at column zero, row zero.
module rgb_prewitt_edge_magnitude (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [7:0]                  i_pixel_blue,
    input  logic [7:0]                  i_pixel_green,
    input  logic [7:0]                  i_pixel_red,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [7:0]                  o_edge_blue,
    output logic [7:0]                  o_edge_green,
    output logic [7:0]                  o_edge_red,
    output logic [rpe_pkg::COL_W-1:0]   o_center_col,
    output logic [rpe_pkg::ROW_W-1:0]   o_center_row,
    output logic                        o_frame_done,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    logic [rpe_pkg::FW_W-1:0] r_frame_width;
    logic [rpe_pkg::FH_W-1:0] r_frame_height;
    logic                     cfg_write;
    rpe_pkg::t_cmd            cmd;
    rpe_pkg::t_sts            sts;

    // Every write completes in its access cycle.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= rpe_pkg::FW_RESET;
            r_frame_height <= rpe_pkg::FH_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == rpe_pkg::REG_FRAME_WIDTH) begin
                r_frame_width <= pwdata[rpe_pkg::FW_W-1:0];
            end else begin
                r_frame_height <= pwdata[rpe_pkg::FH_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == rpe_pkg::REG_FRAME_HEIGHT) begin
            prdata = 32'(r_frame_height);
        end else begin
            prdata = 32'(r_frame_width);
        end
    end

    rpe_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_sts  (sts),
        .o_cmd  (cmd)
    );

    rpe_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_restart     (cfg_write),
        .i_frame_width (r_frame_width),
        .i_frame_height(r_frame_height),
        .i_pixel_blue  (i_pixel_blue),
        .i_pixel_green (i_pixel_green),
        .i_pixel_red   (i_pixel_red),
        .i_ready       (i_ready),
        .o_valid       (o_valid),
        .o_edge_blue   (o_edge_blue),
        .o_edge_green  (o_edge_green),
        .o_edge_red    (o_edge_red),
        .o_center_col  (o_center_col),
        .o_center_row  (o_center_row),
        .o_frame_done  (o_frame_done)
    );

endmodule
